>>> src/lru_register_allocator_top_assert.svh
// Assertion macros shared by the allocator's top level.
`ifndef LRU_REGISTER_ALLOCATOR_TOP_ASSERT_SVH
`define LRU_REGISTER_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clk and disabled during reset.
`define LRA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk and disabled during reset.
`define LRA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/lra_pkg.sv
// Shared types, codes and constants of the register allocator.
package lra_pkg;

	localparam int DEF_PHYS_REGS    = 64;
	localparam int DEF_LOGICAL_REGS = 256;
	localparam int DEF_AGE_BITS     = 32;

	localparam logic [6:0] PHYS_COUNT_RST = 7'd16;

	// Operation codes.
	localparam logic [4:0] FN_RESET       = 5'd0;
	localparam logic [4:0] FN_ALLOC_STATE = 5'd1;
	localparam logic [4:0] FN_ALLOC_STACK = 5'd2;
	localparam logic [4:0] FN_ALLOC_TEMP  = 5'd3;
	localparam logic [4:0] FN_ALLOC_NAMED = 5'd4;
	localparam logic [4:0] FN_DIRTY       = 5'd5;
	localparam logic [4:0] FN_CLEAN       = 5'd6;
	localparam logic [4:0] FN_TOUCH       = 5'd7;
	localparam logic [4:0] FN_PIN         = 5'd8;
	localparam logic [4:0] FN_UNPIN       = 5'd9;
	localparam logic [4:0] FN_LIVE        = 5'd10;
	localparam logic [4:0] FN_LIVE_NOLOAD = 5'd11;
	localparam logic [4:0] FN_LIVE_STACK  = 5'd12;
	localparam logic [4:0] FN_SPILL       = 5'd13;
	localparam logic [4:0] FN_SPILL_STACK = 5'd14;
	localparam logic [4:0] FN_TRANSFER    = 5'd15;
	localparam logic [4:0] FN_ACQUIRE     = 5'd16;
	localparam logic [4:0] FN_RELEASE     = 5'd17;
	localparam logic [4:0] FN_GET_REAL    = 5'd18;

	// Status codes.
	localparam logic [3:0] ST_OK          = 4'd0;
	localparam logic [3:0] ST_TABLE_FULL  = 4'd1;
	localparam logic [3:0] ST_NO_FREE     = 4'd2;
	localparam logic [3:0] ST_NO_HOME     = 4'd3;
	localparam logic [3:0] ST_NAMED_BUSY  = 4'd4;
	localparam logic [3:0] ST_NAMED_BAD   = 4'd5;
	localparam logic [3:0] ST_NOT_TEMP    = 4'd6;
	localparam logic [3:0] ST_SRC_UNALLOC = 4'd7;
	localparam logic [3:0] ST_DST_ALLOC   = 4'd8;
	localparam logic [3:0] ST_NOT_ALLOC   = 4'd9;
	localparam logic [3:0] ST_DBL_RELEASE = 4'd10;

	// Emitted access kinds and bases.
	localparam logic [1:0] EMIT_NONE  = 2'd0;
	localparam logic [1:0] EMIT_LOAD  = 2'd1;
	localparam logic [1:0] EMIT_STORE = 2'd2;
	localparam logic BASE_STATE = 1'b0;
	localparam logic BASE_STACK = 1'b1;

	// Entry field bits.
	localparam int FL_TEMP  = 0;
	localparam int FL_DIRTY = 1;
	localparam int FL_PIN   = 2;
	localparam int PV_BIT   = 6;
	localparam int HV_BIT   = 16;

	typedef struct packed {
		logic [6:0]  phys;
		logic [16:0] shome;
		logic [16:0] khome;
		logic [2:0]  flags;
	} ent_t;

	typedef enum logic [3:0] {
		CMD_NOP       = 4'd0,
		CMD_LATCH     = 4'd1,
		CMD_SIMPLE    = 4'd2,
		CMD_RDE       = 4'd3,
		CMD_LOADE     = 4'd4,
		CMD_RDSRC     = 4'd5,
		CMD_XFER      = 4'd6,
		CMD_EXEC      = 4'd7,
		CMD_GRAB      = 4'd8,
		CMD_SCAN      = 4'd9,
		CMD_RDV       = 4'd10,
		CMD_SPILLV    = 4'd11,
		CMD_POST      = 4'd12,
		CMD_WB        = 4'd13,
		CMD_EMIT_ST   = 4'd14,
		CMD_EMIT_LAST = 4'd15
	} cmd_t;

	typedef struct packed {
		logic simple;
		logic xfer;
		logic fail;
		logic need_obtain;
		logic grab_ok;
		logic second;
		logic scan_last;
		logic best_vld;
		logic store_pend;
	} sts_t;

endpackage

>>> src/lra_ctrl.sv
// Sequencing state machine of the register allocator.
module lra_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  lra_pkg::sts_t sts,
	output lra_pkg::cmd_t cmd
);
	import lra_pkg::*;

	typedef enum logic [14:0] {
		S_IDLE   = 15'b000000000000001,
		S_CHECK  = 15'b000000000000010,
		S_RDSRC  = 15'b000000000000100,
		S_XFER   = 15'b000000000001000,
		S_LOADE  = 15'b000000000010000,
		S_EXEC   = 15'b000000000100000,
		S_GRAB   = 15'b000000001000000,
		S_SCAN   = 15'b000000010000000,
		S_SCEND  = 15'b000000100000000,
		S_PICK   = 15'b000001000000000,
		S_SPILLV = 15'b000010000000000,
		S_POST   = 15'b000100000000000,
		S_WB     = 15'b001000000000000,
		S_FIN    = 15'b010000000000000,
		S_LAST   = 15'b100000000000000
	} state_t;

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		cmd     = CMD_NOP;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd     = CMD_LATCH;
					state_n = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.simple) begin
					cmd     = CMD_SIMPLE;
					state_n = S_FIN;
				end else begin
					cmd     = CMD_RDE;
					state_n = sts.xfer ? S_RDSRC : S_LOADE;
				end
			end
			S_RDSRC: begin
				cmd     = CMD_RDSRC;
				state_n = S_XFER;
			end
			S_XFER: begin
				cmd     = CMD_XFER;
				state_n = sts.fail ? S_FIN : S_WB;
			end
			S_LOADE: begin
				cmd     = CMD_LOADE;
				state_n = S_EXEC;
			end
			S_EXEC: begin
				cmd = CMD_EXEC;
				if (sts.fail) begin
					state_n = S_FIN;
				end else if (sts.need_obtain) begin
					state_n = S_GRAB;
				end else begin
					state_n = S_WB;
				end
			end
			S_GRAB: begin
				cmd = CMD_GRAB;
				if (sts.grab_ok) begin
					state_n = S_POST;
				end else if (sts.second) begin
					state_n = S_FIN;
				end else begin
					state_n = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd     = CMD_SCAN;
				state_n = sts.scan_last ? S_SCEND : S_SCAN;
			end
			S_SCEND: begin
				state_n = S_PICK;
			end
			S_PICK: begin
				if (sts.best_vld) begin
					cmd     = CMD_RDV;
					state_n = S_SPILLV;
				end else begin
					state_n = S_GRAB;
				end
			end
			S_SPILLV: begin
				cmd     = CMD_SPILLV;
				state_n = sts.fail ? S_FIN : S_GRAB;
			end
			S_POST: begin
				cmd     = CMD_POST;
				state_n = S_WB;
			end
			S_WB: begin
				cmd     = CMD_WB;
				state_n = S_FIN;
			end
			S_FIN: begin
				if (sts.store_pend) begin
					cmd = CMD_EMIT_ST;
				end
				state_n = S_LAST;
			end
			S_LAST: begin
				cmd     = CMD_EMIT_LAST;
				state_n = S_IDLE;
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

>>> src/lra_dp.sv
// Datapath of the register allocator: entry memory, register pool and result registers.
module lra_dp #(
	parameter int PHYS_REGS    = lra_pkg::DEF_PHYS_REGS,
	parameter int LOGICAL_REGS = lra_pkg::DEF_LOGICAL_REGS,
	parameter int AGE_BITS     = lra_pkg::DEF_AGE_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  lra_pkg::cmd_t cmd,
	output lra_pkg::sts_t sts,
	input  logic          cfg_we,
	input  logic [6:0]    cfg_wdata,
	input  logic [4:0]    func,
	input  logic [7:0]    logical_id,
	input  logic [7:0]    source_id,
	input  logic [15:0]   location_offset,
	input  logic [5:0]    phys_index,
	output logic          strobe,
	output logic [3:0]    status,
	output logic [7:0]    handle,
	output logic [5:0]    phys_reg,
	output logic [1:0]    emit_kind,
	output logic          mem_base,
	output logic [15:0]   mem_offset,
	output logic          loaded,
	output logic          last
);
	import lra_pkg::*;

	localparam int LIDX_W = $clog2(LOGICAL_REGS);
	localparam int CNT_W  = LIDX_W + 1;
	localparam int PIDX_W = $clog2(PHYS_REGS);
	localparam logic [CNT_W-1:0]    CNT_MAX   = CNT_W'(LOGICAL_REGS);
	localparam logic [6:0]          POOL_MAX  = 7'(PHYS_REGS);
	localparam logic [AGE_BITS-1:0] AGE_ONE   = AGE_BITS'(1);
	localparam logic [AGE_BITS-1:0] AGE_TWO   = AGE_BITS'(2);
	localparam logic [AGE_BITS-1:0] AGE_BACK  = AGE_BITS'(8);

	// Entry memory, one write and one registered read per cycle.
	ent_t                ent_mem [LOGICAL_REGS];
	logic [AGE_BITS-1:0] age_mem [LOGICAL_REGS];
	ent_t                mem_q;
	logic [AGE_BITS-1:0] mem_age_q;
	logic                wr_en;
	logic [LIDX_W-1:0]   wr_addr, rd_addr;
	ent_t                wr_ent;
	logic [AGE_BITS-1:0] wr_age;

	// Control state.
	logic [CNT_W-1:0]     cnt_q, n_cnt;
	logic [AGE_BITS-1:0]  age_ctr_q, n_age_ctr;
	logic [PHYS_REGS-1:0] piu_q, n_piu;
	logic [6:0]           pc_q;
	logic                 strobe_q, n_strobe;
	logic                 stp_q, n_stp, ldp_q, n_ldp;
	logic                 second_q, n_second;
	logic                 best_vld_q, n_best_vld;
	logic                 cmp_vld_s1;

	// Operation context.
	logic [4:0]           func_q, n_func;
	logic [7:0]           e_q, n_e, src_q, n_src;
	logic [15:0]          off_q, n_off;
	logic [5:0]           pidx_q, n_pidx;
	ent_t                 cur_q, n_cur;
	logic [AGE_BITS-1:0]  cur_age_q, n_cur_age;
	logic [3:0]           st_q, n_st;
	logic [7:0]           handle_q, n_handle;
	logic [5:0]           rp_q, n_rp;
	logic                 use_cur_q, n_use_cur;
	logic                 loaded_q, n_loaded;
	logic [5:0]           sphys_q, n_sphys, lphys_q, n_lphys;
	logic                 sbase_q, n_sbase, lbase_q, n_lbase;
	logic [15:0]          soff_q, n_soff, loff_q, n_loff;
	logic [CNT_W-1:0]     scan_i_q, n_scan_i;
	logic [LIDX_W-1:0]    cmp_idx_s1;
	logic [LIDX_W-1:0]    best_idx_q, n_best_idx;
	logic [AGE_BITS-1:0]  best_age_q, n_best_age;

	// Result registers.
	logic [3:0]  o_status_q, n_o_status;
	logic [7:0]  o_handle_q, n_o_handle;
	logic [5:0]  o_phys_q, n_o_phys;
	logic [1:0]  o_kind_q, n_o_kind;
	logic        o_base_q, n_o_base;
	logic [15:0] o_off_q, n_o_off;
	logic        o_loaded_q, n_o_loaded;
	logic        o_last_q, n_o_last;

	logic [6:0]        pool;
	logic              g_found;
	logic [PIDX_W-1:0] g_idx;
	logic              inv;
	logic [LIDX_W-1:0] e_idx, src_idx, cnt_idx;
	logic              cur_free_ok, mem_free_ok;
	logic              fail, need_obtain, grab_ok;

	assign pool    = (pc_q > POOL_MAX) ? POOL_MAX : pc_q;
	assign e_idx   = e_q[LIDX_W-1:0];
	assign src_idx = src_q[LIDX_W-1:0];
	assign cnt_idx = cnt_q[LIDX_W-1:0];

	assign inv = (func_q >= FN_DIRTY) && (func_q <= FN_GET_REAL) &&
		((9'(e_q) >= 9'(cnt_q)) || ((func_q == FN_TRANSFER) && (9'(src_q) >= 9'(cnt_q))));

	assign cur_free_ok = (32'(cur_q.phys[5:0]) < PHYS_REGS) &&
		piu_q[cur_q.phys[PIDX_W-1:0]];
	assign mem_free_ok = (32'(mem_q.phys[5:0]) < PHYS_REGS) &&
		piu_q[mem_q.phys[PIDX_W-1:0]];

	// Lowest free register below the pool size.
	always_comb begin
		g_found = 1'b0;
		g_idx   = '0;
		for (int i = PHYS_REGS - 1; i >= 0; i--) begin
			if (!piu_q[i] && (7'(i) < pool)) begin
				g_found = 1'b1;
				g_idx   = PIDX_W'(i);
			end
		end
	end

	always_comb begin
		n_cnt = cnt_q;   n_age_ctr = age_ctr_q;   n_piu = piu_q;
		n_strobe = 1'b0; n_stp = stp_q;           n_ldp = ldp_q;
		n_second = second_q; n_best_vld = best_vld_q;
		n_func = func_q; n_e = e_q; n_src = src_q; n_off = off_q; n_pidx = pidx_q;
		n_cur = cur_q;   n_cur_age = cur_age_q;   n_st = st_q;
		n_handle = handle_q; n_rp = rp_q; n_use_cur = use_cur_q; n_loaded = loaded_q;
		n_sphys = sphys_q; n_sbase = sbase_q; n_soff = soff_q;
		n_lphys = lphys_q; n_lbase = lbase_q; n_loff = loff_q;
		n_scan_i = scan_i_q; n_best_idx = best_idx_q; n_best_age = best_age_q;
		n_o_status = o_status_q; n_o_handle = o_handle_q; n_o_phys = o_phys_q;
		n_o_kind = o_kind_q; n_o_base = o_base_q; n_o_off = o_off_q;
		n_o_loaded = o_loaded_q; n_o_last = o_last_q;
		wr_en = 1'b0; wr_addr = e_idx; wr_ent = cur_q; wr_age = cur_age_q;
		rd_addr = e_idx;
		fail = 1'b0; need_obtain = 1'b0; grab_ok = 1'b0;

		// Oldest spillable holder, one entry per cycle behind the read.
		if (cmp_vld_s1 && mem_q.phys[PV_BIT] && !mem_q.flags[FL_PIN] &&
			!mem_q.flags[FL_TEMP] && (!best_vld_q || (mem_age_q < best_age_q))) begin
			n_best_vld = 1'b1;
			n_best_idx = cmp_idx_s1;
			n_best_age = mem_age_q;
		end

		case (cmd)
			CMD_LATCH: begin
				n_func = func; n_e = logical_id; n_src = source_id;
				n_off = location_offset; n_pidx = phys_index;
				n_st = ST_OK; n_handle = '0; n_rp = '0; n_loaded = 1'b0;
				n_stp = 1'b0; n_ldp = 1'b0; n_second = 1'b0;
			end
			CMD_SIMPLE: begin
				n_use_cur = 1'b0;
				wr_addr   = cnt_idx;
				wr_age    = age_ctr_q;
				wr_ent    = '0;
				if (inv) begin
					n_st = ST_NOT_ALLOC;
				end else begin
					case (func_q)
						FN_RESET: begin
							n_piu = '0;
							n_cnt = '0;
						end
						FN_ALLOC_STATE, FN_ALLOC_STACK, FN_ALLOC_TEMP: begin
							if (cnt_q >= CNT_MAX) begin
								n_st = ST_TABLE_FULL;
							end else begin
								if (func_q == FN_ALLOC_STATE) begin
									wr_ent.shome = {1'b1, off_q};
								end else if (func_q == FN_ALLOC_STACK) begin
									wr_ent.khome = {1'b1, off_q};
								end else begin
									wr_ent.flags[FL_TEMP] = 1'b1;
								end
								wr_en     = 1'b1;
								n_age_ctr = age_ctr_q + AGE_ONE;
								n_cnt     = cnt_q + 1'b1;
								n_handle  = 8'(cnt_q);
							end
						end
						FN_ALLOC_NAMED: begin
							if ({1'b0, pidx_q} >= pool) begin
								n_st = ST_NAMED_BAD;
							end else if (piu_q[pidx_q[PIDX_W-1:0]]) begin
								n_st = ST_NAMED_BUSY;
							end else if (cnt_q >= CNT_MAX) begin
								n_st = ST_TABLE_FULL;
							end else begin
								wr_ent.phys           = {1'b1, pidx_q};
								wr_ent.flags[FL_TEMP] = 1'b1;
								wr_ent.flags[FL_PIN]  = 1'b1;
								wr_en     = 1'b1;
								n_age_ctr = age_ctr_q + AGE_ONE;
								n_cnt     = cnt_q + 1'b1;
								n_handle  = 8'(cnt_q);
								n_rp      = pidx_q;
								n_piu[pidx_q[PIDX_W-1:0]] = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end
			CMD_RDE: begin
				n_use_cur = 1'b1;
			end
			CMD_LOADE: begin
				n_cur = mem_q; n_cur_age = mem_age_q;
			end
			CMD_RDSRC: begin
				n_cur = mem_q; n_cur_age = mem_age_q;
				rd_addr = src_idx;
			end
			CMD_XFER: begin
				if (!mem_q.phys[PV_BIT]) begin
					fail = 1'b1; n_st = ST_SRC_UNALLOC;
				end else if (cur_q.phys[PV_BIT]) begin
					fail = 1'b1; n_st = ST_DST_ALLOC;
				end else begin
					wr_en       = 1'b1;
					wr_addr     = src_idx;
					wr_ent      = mem_q;
					wr_ent.phys = '0;
					wr_age      = mem_age_q;
					n_cur.phys  = mem_q.phys;
					n_cur_age   = age_ctr_q;
					n_age_ctr   = age_ctr_q + AGE_ONE;
				end
			end
			CMD_EXEC: begin
				case (func_q)
					FN_DIRTY, FN_CLEAN, FN_TOUCH: begin
						if (func_q == FN_DIRTY) n_cur.flags[FL_DIRTY] = 1'b1;
						if (func_q == FN_CLEAN) n_cur.flags[FL_DIRTY] = 1'b0;
						n_cur_age = age_ctr_q; n_age_ctr = age_ctr_q + AGE_ONE;
					end
					FN_PIN:   n_cur.flags[FL_PIN] = 1'b1;
					FN_UNPIN: n_cur.flags[FL_PIN] = 1'b0;
					FN_GET_REAL: begin
						if (!cur_q.phys[PV_BIT]) begin
							fail = 1'b1; n_st = ST_NOT_ALLOC;
						end
					end
					FN_LIVE, FN_LIVE_NOLOAD: begin
						if (cur_q.phys[PV_BIT]) begin
							// The plain live form stamps twice.
							if (func_q == FN_LIVE) begin
								n_cur_age = age_ctr_q + AGE_ONE;
								n_age_ctr = age_ctr_q + AGE_TWO;
							end else begin
								n_cur_age = age_ctr_q;
								n_age_ctr = age_ctr_q + AGE_ONE;
							end
						end else if (!cur_q.shome[HV_BIT] && !cur_q.khome[HV_BIT]) begin
							fail = 1'b1; n_st = ST_NO_HOME;
						end else begin
							need_obtain = 1'b1;
						end
					end
					FN_LIVE_STACK: begin
						if (!cur_q.shome[HV_BIT]) begin
							fail = 1'b1; n_st = ST_NO_HOME;
						end else if (cur_q.phys[PV_BIT]) begin
							n_cur.flags[FL_DIRTY] = 1'b1;
							n_cur_age = age_ctr_q + AGE_ONE;
							n_age_ctr = age_ctr_q + AGE_TWO;
						end else begin
							need_obtain = 1'b1;
						end
					end
					FN_SPILL, FN_SPILL_STACK: begin
						if ((func_q == FN_SPILL) ? (!cur_q.shome[HV_BIT] && !cur_q.khome[HV_BIT])
							: !cur_q.shome[HV_BIT]) begin
							fail = 1'b1; n_st = ST_NO_HOME;
						end else if (cur_q.flags[FL_PIN]) begin
							n_cur_age = age_ctr_q; n_age_ctr = age_ctr_q + AGE_ONE;
						end else begin
							if (cur_q.phys[PV_BIT]) begin
								if (func_q == FN_SPILL_STACK) begin
									n_stp = 1'b1; n_sbase = BASE_STACK;
									n_soff = cur_q.shome[15:0];
								end else if (cur_q.flags[FL_DIRTY]) begin
									n_stp = 1'b1;
									n_sbase = cur_q.shome[HV_BIT] ? BASE_STATE : BASE_STACK;
									n_soff  = cur_q.shome[HV_BIT] ? cur_q.shome[15:0]
										: cur_q.khome[15:0];
								end
								n_sphys = cur_q.phys[5:0];
							end
							if (cur_q.phys[PV_BIT] && !cur_free_ok) begin
								fail = 1'b1; n_st = ST_DBL_RELEASE;
							end else begin
								if (cur_q.phys[PV_BIT]) begin
									n_piu[cur_q.phys[PIDX_W-1:0]] = 1'b0;
								end
								n_cur.phys = '0;
								n_cur.flags[FL_DIRTY] = 1'b0;
							end
						end
					end
					FN_ACQUIRE: begin
						if (!cur_q.flags[FL_TEMP]) begin
							fail = 1'b1; n_st = ST_NOT_TEMP;
						end else if (cur_q.phys[PV_BIT]) begin
							n_cur.flags[FL_DIRTY] = 1'b1;
							n_cur_age = age_ctr_q; n_age_ctr = age_ctr_q + AGE_ONE;
						end else begin
							need_obtain = 1'b1;
						end
					end
					FN_RELEASE: begin
						if (!cur_q.flags[FL_TEMP]) begin
							fail = 1'b1; n_st = ST_NOT_TEMP;
						end else if (cur_q.phys[PV_BIT] && !cur_free_ok) begin
							fail = 1'b1; n_st = ST_DBL_RELEASE;
						end else begin
							if (cur_q.phys[PV_BIT]) begin
								n_piu[cur_q.phys[PIDX_W-1:0]] = 1'b0;
							end
							n_cur.phys = '0;
							n_cur_age  = age_ctr_q - AGE_BACK;
						end
					end
					default: begin
					end
				endcase
			end
			CMD_GRAB: begin
				if (g_found) begin
					grab_ok    = 1'b1;
					n_piu[g_idx] = 1'b1;
					n_cur.phys = {1'b1, 6'(g_idx)};
				end else if (!second_q) begin
					n_second   = 1'b1;
					n_scan_i   = '0;
					n_best_vld = 1'b0;
				end else begin
					n_st = ST_NO_FREE;
				end
			end
			CMD_SCAN: begin
				rd_addr  = scan_i_q[LIDX_W-1:0];
				n_scan_i = scan_i_q + 1'b1;
			end
			CMD_RDV: begin
				rd_addr = best_idx_q;
			end
			CMD_SPILLV: begin
				if (!mem_q.shome[HV_BIT] && !mem_q.khome[HV_BIT]) begin
					fail = 1'b1; n_st = ST_NO_HOME;
				end else begin
					if (mem_q.flags[FL_DIRTY]) begin
						n_stp   = 1'b1;
						n_sphys = mem_q.phys[5:0];
						n_sbase = mem_q.shome[HV_BIT] ? BASE_STATE : BASE_STACK;
						n_soff  = mem_q.shome[HV_BIT] ? mem_q.shome[15:0] : mem_q.khome[15:0];
					end
					if (!mem_free_ok) begin
						fail = 1'b1; n_st = ST_DBL_RELEASE;
					end else begin
						n_piu[mem_q.phys[PIDX_W-1:0]] = 1'b0;
						wr_en   = 1'b1;
						wr_addr = best_idx_q;
						wr_ent  = mem_q;
						wr_ent.phys = '0;
						wr_ent.flags[FL_DIRTY] = 1'b0;
						wr_age  = mem_age_q;
					end
				end
			end
			CMD_POST: begin
				case (func_q)
					FN_LIVE: begin
						n_ldp   = 1'b1;
						n_lphys = cur_q.phys[5:0];
						n_lbase = cur_q.shome[HV_BIT] ? BASE_STATE : BASE_STACK;
						n_loff  = cur_q.shome[HV_BIT] ? cur_q.shome[15:0] : cur_q.khome[15:0];
						n_cur.flags[FL_DIRTY] = 1'b0;
						n_cur_age = age_ctr_q + AGE_ONE;
						n_age_ctr = age_ctr_q + AGE_TWO;
					end
					FN_LIVE_NOLOAD: begin
						n_loaded  = 1'b1;
						n_cur_age = age_ctr_q;
						n_age_ctr = age_ctr_q + AGE_ONE;
					end
					FN_LIVE_STACK: begin
						// Loads from the stack at the state home's offset.
						n_ldp   = 1'b1;
						n_lphys = cur_q.phys[5:0];
						n_lbase = BASE_STACK;
						n_loff  = cur_q.shome[15:0];
						n_cur.flags[FL_DIRTY] = 1'b1;
						n_cur_age = age_ctr_q + AGE_ONE;
						n_age_ctr = age_ctr_q + AGE_TWO;
					end
					FN_ACQUIRE: begin
						n_cur.flags[FL_DIRTY] = 1'b1;
						n_cur_age = age_ctr_q;
						n_age_ctr = age_ctr_q + AGE_ONE;
					end
					default: begin
					end
				endcase
			end
			CMD_WB: begin
				wr_en = 1'b1;
			end
			CMD_EMIT_ST: begin
				n_strobe = 1'b1;
				n_o_status = ST_OK; n_o_handle = '0; n_o_phys = sphys_q;
				n_o_kind = EMIT_STORE; n_o_base = sbase_q; n_o_off = soff_q;
				n_o_loaded = loaded_q; n_o_last = 1'b0;
			end
			CMD_EMIT_LAST: begin
				n_strobe   = 1'b1;
				n_o_loaded = loaded_q;
				n_o_last   = 1'b1;
				if (ldp_q) begin
					n_o_status = ST_OK; n_o_handle = '0; n_o_phys = lphys_q;
					n_o_kind = EMIT_LOAD; n_o_base = lbase_q; n_o_off = loff_q;
				end else begin
					n_o_status = st_q; n_o_handle = handle_q;
					n_o_kind = EMIT_NONE; n_o_base = BASE_STATE; n_o_off = '0;
					if (st_q != ST_OK) begin
						n_o_phys = '0;
					end else if (use_cur_q) begin
						n_o_phys = cur_q.phys[PV_BIT] ? cur_q.phys[5:0] : 6'd0;
					end else begin
						n_o_phys = rp_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ent_mem[wr_addr] <= wr_ent;
			age_mem[wr_addr] <= wr_age;
		end
		mem_q     <= ent_mem[rd_addr];
		mem_age_q <= age_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; age_ctr_q <= '0; piu_q <= '0; pc_q <= PHYS_COUNT_RST;
			strobe_q <= 1'b0; stp_q <= 1'b0; ldp_q <= 1'b0; second_q <= 1'b0;
			best_vld_q <= 1'b0; cmp_vld_s1 <= 1'b0;
		end else begin
			cnt_q <= n_cnt; age_ctr_q <= n_age_ctr; piu_q <= n_piu;
			if (cfg_we) begin
				pc_q <= cfg_wdata;
			end
			strobe_q <= n_strobe; stp_q <= n_stp; ldp_q <= n_ldp; second_q <= n_second;
			best_vld_q <= n_best_vld;
			cmp_vld_s1 <= (cmd == CMD_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		func_q <= n_func; e_q <= n_e; src_q <= n_src; off_q <= n_off; pidx_q <= n_pidx;
		cur_q <= n_cur; cur_age_q <= n_cur_age; st_q <= n_st;
		handle_q <= n_handle; rp_q <= n_rp; use_cur_q <= n_use_cur; loaded_q <= n_loaded;
		sphys_q <= n_sphys; sbase_q <= n_sbase; soff_q <= n_soff;
		lphys_q <= n_lphys; lbase_q <= n_lbase; loff_q <= n_loff;
		scan_i_q <= n_scan_i; cmp_idx_s1 <= scan_i_q[LIDX_W-1:0];
		best_idx_q <= n_best_idx; best_age_q <= n_best_age;
		o_status_q <= n_o_status; o_handle_q <= n_o_handle; o_phys_q <= n_o_phys;
		o_kind_q <= n_o_kind; o_base_q <= n_o_base; o_off_q <= n_o_off;
		o_loaded_q <= n_o_loaded; o_last_q <= n_o_last;
	end

	always_comb begin
		sts.simple      = inv || (func_q <= FN_ALLOC_NAMED) || (func_q > FN_GET_REAL);
		sts.xfer        = (func_q == FN_TRANSFER);
		sts.fail        = fail;
		sts.need_obtain = need_obtain;
		sts.grab_ok     = grab_ok;
		sts.second      = second_q;
		sts.scan_last   = ((scan_i_q + 1'b1) >= cnt_q);
		sts.best_vld    = best_vld_q;
		sts.store_pend  = stp_q;
	end

	assign strobe     = strobe_q;
	assign status     = o_status_q;
	assign handle     = o_handle_q;
	assign phys_reg   = o_phys_q;
	assign emit_kind  = o_kind_q;
	assign mem_base   = o_base_q;
	assign mem_offset = o_off_q;
	assign loaded     = o_loaded_q;
	assign last       = o_last_q;

endmodule

>>> src/lru_register_allocator_top.sv
// Top level of the LRU physical register allocator with spill.
// The block maps logical register entries onto a pool of physical registers and
// reports the memory accesses that each command causes. A command transfers in at
// a clock edge where start is high and busy is low. Busy then stays high until the
// command's final result has been issued, and that result shows in the first cycle
// in which busy is low again. Each command gives one or two results. Each result is
// shown on the result ports for exactly one cycle with strobe high. A spill store
// comes first, then either a load or a closing result, and last marks the final one.
// The receiver cannot stall, so it must take every result in the cycle it appears.
// Busy time depends on the command. Allocations, reset, unused codes and commands
// that name a handle that does not exist go from the check to the result states.
// A command that reads and writes back its entry first loads it, and a transfer
// also reads the source entry. A command that takes a free register grabs one
// before the write back. When a register is needed and none is free, the oldest
// spillable entry is found by reading every allocated entry through the single
// read port of the entry memory, one entry per cycle, and is spilled. The pool
// size register is written through cfg_we and cfg_wdata and must only be written
// while busy is low.
`include "lru_register_allocator_top_assert.svh"

module lru_register_allocator_top #(
	parameter int PHYS_REGS    = lra_pkg::DEF_PHYS_REGS,
	parameter int LOGICAL_REGS = lra_pkg::DEF_LOGICAL_REGS,
	parameter int AGE_BITS     = lra_pkg::DEF_AGE_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,
	input  logic [4:0]  func,
	input  logic [7:0]  logical_id,
	input  logic [7:0]  source_id,
	input  logic [15:0] location_offset,
	input  logic [5:0]  phys_index,
	output logic        strobe,
	output logic [3:0]  status,
	output logic [7:0]  handle,
	output logic [5:0]  phys_reg,
	output logic [1:0]  emit_kind,
	output logic        mem_base,
	output logic [15:0] mem_offset,
	output logic        loaded,
	output logic        last
);
	import lra_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// The controller steps through the phases of a command; the datapath does the work.
	lra_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	lra_dp #(
		.PHYS_REGS    (PHYS_REGS),
		.LOGICAL_REGS (LOGICAL_REGS),
		.AGE_BITS     (AGE_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.func            (func),
		.logical_id      (logical_id),
		.source_id       (source_id),
		.location_offset (location_offset),
		.phys_index      (phys_index),
		.strobe          (strobe),
		.status          (status),
		.handle          (handle),
		.phys_reg        (phys_reg),
		.emit_kind       (emit_kind),
		.mem_base        (mem_base),
		.mem_offset      (mem_offset),
		.loaded          (loaded),
		.last            (last)
	);

	// A transfer in makes the block busy in the next cycle.
	`LRA_ASSERT_NXT(a_accept_busy, start && !busy, busy, "busy did not rise after accept")
	// A result that is not the last one is a store, followed at once by the last one.
	`LRA_ASSERT_IMP(a_mid_store, strobe && !last, emit_kind == EMIT_STORE, "early result not a store")
	`LRA_ASSERT_NXT(a_store_then_last, strobe && !last, strobe && last, "no final result after store")
	// The final result of a command is never directly followed by another result.
	`LRA_ASSERT_NXT(a_last_gap, strobe && last, !strobe, "result right after final result")

endmodule

>>> tb/tb_lru_register_allocator_top.sv
// Self-checking testbench for the LRU physical register allocator with spill.
`timescale 1ns / 100ps

module tb_lru_register_allocator_top;
	import lra_pkg::*;

	localparam int NPHYS = 64;
	localparam int NLOG  = 256;
	localparam int WATCHDOG_LIMIT = 20000;

	// One result transfer as seen on the result ports.
	typedef struct packed {
		logic [3:0]  status;
		logic [7:0]  handle;
		logic [5:0]  phys_reg;
		logic [1:0]  emit_kind;
		logic        mem_base;
		logic [15:0] mem_offset;
		logic        loaded;
		logic        last;
	} alloc_result_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        cfg_we;
	logic [6:0]  cfg_wdata;
	logic [4:0]  func;
	logic [7:0]  logical_id;
	logic [7:0]  source_id;
	logic [15:0] location_offset;
	logic [5:0]  phys_index;
	logic        strobe;
	logic [3:0]  status;
	logic [7:0]  handle;
	logic [5:0]  phys_reg;
	logic [1:0]  emit_kind;
	logic        mem_base;
	logic [15:0] mem_offset;
	logic        loaded;
	logic        last;

	lru_register_allocator_top uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .func(func),
		.logical_id(logical_id), .source_id(source_id),
		.location_offset(location_offset), .phys_index(phys_index),
		.strobe(strobe), .status(status), .handle(handle), .phys_reg(phys_reg),
		.emit_kind(emit_kind), .mem_base(mem_base), .mem_offset(mem_offset),
		.loaded(loaded), .last(last)
	);

	always #5 clk = ~clk;

	// Shadow copy of the allocator state, kept in step with accepted commands.
	logic        sh_in_use [NPHYS];
	logic [6:0]  sh_phys [NLOG];
	logic [16:0] sh_shome [NLOG];
	logic [16:0] sh_khome [NLOG];
	logic [2:0]  sh_flags [NLOG];
	logic [31:0] sh_age [NLOG];
	int unsigned sh_count;
	logic [31:0] sh_clock;
	logic [6:0]  sh_pool_size;

	// Results of the command being predicted, then the queue of pending expectations.
	alloc_result_t step_res [$];
	alloc_result_t expected_results [$];

	int mismatches;
	int results_seen;
	int commands_sent;
	int idle_pct;
	int quiet_cycles;
	logic timed_out;

	function automatic int pool_limit();
		return (sh_pool_size > NPHYS) ? NPHYS : int'(sh_pool_size);
	endfunction

	function automatic void stamp_entry(int e);
		sh_age[e] = sh_clock;
		sh_clock = sh_clock + 1;
	endfunction

	function automatic void push_result(logic [3:0] st, logic [7:0] h, logic [5:0] p,
			logic [1:0] k, logic b, logic [15:0] off);
		alloc_result_t r;
		r = '0;
		r.status = st; r.handle = h; r.phys_reg = p;
		r.emit_kind = k; r.mem_base = b; r.mem_offset = off;
		if (step_res.size() < 2) step_res.push_back(r);
	endfunction

	// Lowest free register below the pool size, or -1.
	function automatic int take_free();
		for (int i = 0; i < pool_limit(); i++) begin
			if (!sh_in_use[i]) begin
				sh_in_use[i] = 1'b1;
				return i;
			end
		end
		return -1;
	endfunction

	function automatic logic [3:0] free_reg(logic [6:0] p);
		if (!sh_in_use[p[5:0]]) return ST_DBL_RELEASE;
		sh_in_use[p[5:0]] = 1'b0;
		return ST_OK;
	endfunction

	function automatic logic [3:0] spill_one(int e);
		logic [3:0] st;
		if (!sh_shome[e][HV_BIT] && !sh_khome[e][HV_BIT]) return ST_NO_HOME;
		if (sh_flags[e][FL_PIN]) begin
			stamp_entry(e);
			return ST_OK;
		end
		if (sh_phys[e][PV_BIT]) begin
			if (sh_flags[e][FL_DIRTY]) begin
				if (sh_shome[e][HV_BIT])
					push_result(ST_OK, 8'd0, sh_phys[e][5:0], EMIT_STORE, BASE_STATE,
						sh_shome[e][15:0]);
				else
					push_result(ST_OK, 8'd0, sh_phys[e][5:0], EMIT_STORE, BASE_STACK,
						sh_khome[e][15:0]);
			end
			st = free_reg(sh_phys[e]);
			if (st != ST_OK) return st;
			sh_phys[e] = '0;
		end
		sh_flags[e][FL_DIRTY] = 1'b0;
		return ST_OK;
	endfunction

	// Spill the oldest holder that is neither pinned nor temporary.
	function automatic logic [3:0] evict_oldest();
		int best;
		logic [31:0] best_age;
		best = -1;
		best_age = '0;
		for (int i = 0; i < sh_count; i++) begin
			if (!sh_phys[i][PV_BIT] || sh_flags[i][FL_PIN] || sh_flags[i][FL_TEMP]) continue;
			if (best < 0 || sh_age[i] < best_age) begin
				best = i;
				best_age = sh_age[i];
			end
		end
		return (best >= 0) ? spill_one(best) : ST_OK;
	endfunction

	function automatic logic [3:0] obtain_reg(int e);
		int p;
		logic [3:0] st;
		p = take_free();
		if (p < 0) begin
			st = evict_oldest();
			if (st != ST_OK) return st;
			p = take_free();
			if (p < 0) return ST_NO_FREE;
		end
		sh_phys[e] = {1'b1, 6'(p)};
		return ST_OK;
	endfunction

	function automatic logic [3:0] bring_live(int e, output logic assigned);
		logic [3:0] st;
		assigned = 1'b0;
		if (sh_phys[e][PV_BIT]) begin
			stamp_entry(e);
			return ST_OK;
		end
		if (!sh_shome[e][HV_BIT] && !sh_khome[e][HV_BIT]) return ST_NO_HOME;
		st = obtain_reg(e);
		if (st != ST_OK) return st;
		stamp_entry(e);
		assigned = 1'b1;
		return ST_OK;
	endfunction

	function automatic logic [3:0] create_entry(logic [2:0] fl, logic [16:0] sh,
			logic [16:0] kh, logic [6:0] ph, inout int h);
		int e;
		if (sh_count >= NLOG) return ST_TABLE_FULL;
		e = sh_count;
		sh_count++;
		sh_phys[e] = ph; sh_shome[e] = sh; sh_khome[e] = kh; sh_flags[e] = fl;
		stamp_entry(e);
		h = e;
		return ST_OK;
	endfunction

	// Works out the results of one command and appends them to the expectations.
	function automatic void predict_command(logic [4:0] fn, logic [7:0] lid, logic [7:0] sid,
			logic [15:0] off, logic [5:0] pidx);
		int e, src, rep, newh;
		logic [3:0] st;
		logic [7:0] h;
		logic [5:0] rp;
		logic assigned, load_done, ld, valid_fn;
		e = lid; src = sid;
		st = ST_OK; rep = -1; newh = -1; h = '0; rp = '0;
		assigned = 0; load_done = 0; ld = 0;
		step_res.delete();
		valid_fn = (fn >= FN_DIRTY && fn <= FN_GET_REAL);
		if (valid_fn && (e >= sh_count || (fn == FN_TRANSFER && src >= sh_count))) begin
			st = ST_NOT_ALLOC;
			valid_fn = 0;
		end
		if (valid_fn) rep = e;
		if (st == ST_OK) begin
			case (fn)
			FN_RESET: begin
				foreach (sh_in_use[i]) sh_in_use[i] = 1'b0;
				sh_count = 0;
			end
			FN_ALLOC_STATE: st = create_entry(3'b000, {1'b1, off}, '0, '0, newh);
			FN_ALLOC_STACK: st = create_entry(3'b000, '0, {1'b1, off}, '0, newh);
			FN_ALLOC_TEMP: st = create_entry(3'b001, '0, '0, '0, newh);
			FN_ALLOC_NAMED: begin
				if (pidx >= pool_limit()) st = ST_NAMED_BAD;
				else if (sh_in_use[pidx]) st = ST_NAMED_BUSY;
				else begin
					st = create_entry(3'b101, '0, '0, {1'b1, pidx}, newh);
					if (st == ST_OK) sh_in_use[pidx] = 1'b1;
				end
			end
			FN_DIRTY: begin sh_flags[e][FL_DIRTY] = 1; stamp_entry(e); end
			FN_CLEAN: begin sh_flags[e][FL_DIRTY] = 0; stamp_entry(e); end
			FN_TOUCH: stamp_entry(e);
			FN_PIN: sh_flags[e][FL_PIN] = 1;
			FN_UNPIN: sh_flags[e][FL_PIN] = 0;
			FN_LIVE: begin
				st = bring_live(e, assigned);
				if (st == ST_OK) begin
					if (assigned) begin
						if (sh_shome[e][HV_BIT])
							push_result(ST_OK, 8'd0, sh_phys[e][5:0], EMIT_LOAD, BASE_STATE,
								sh_shome[e][15:0]);
						else
							push_result(ST_OK, 8'd0, sh_phys[e][5:0], EMIT_LOAD, BASE_STACK,
								sh_khome[e][15:0]);
						load_done = 1;
						sh_flags[e][FL_DIRTY] = 0;
					end
					stamp_entry(e);
				end
			end
			FN_LIVE_NOLOAD: begin
				st = bring_live(e, assigned);
				ld = (st == ST_OK) && assigned;
			end
			FN_LIVE_STACK: begin
				if (!sh_shome[e][HV_BIT]) st = ST_NO_HOME;
				else begin
					st = bring_live(e, assigned);
					if (st == ST_OK) begin
						// Reloads from the stack slot at the state offset.
						if (assigned) begin
							push_result(ST_OK, 8'd0, sh_phys[e][5:0], EMIT_LOAD, BASE_STACK,
								sh_shome[e][15:0]);
							load_done = 1;
						end
						sh_flags[e][FL_DIRTY] = 1;
						stamp_entry(e);
					end
				end
			end
			FN_SPILL: st = spill_one(e);
			FN_SPILL_STACK: begin
				if (!sh_shome[e][HV_BIT]) st = ST_NO_HOME;
				else if (sh_flags[e][FL_PIN]) stamp_entry(e);
				else begin
					if (sh_phys[e][PV_BIT]) begin
						push_result(ST_OK, 8'd0, sh_phys[e][5:0], EMIT_STORE, BASE_STACK,
							sh_shome[e][15:0]);
						st = free_reg(sh_phys[e]);
						if (st == ST_OK) sh_phys[e] = '0;
					end
					if (st == ST_OK) sh_flags[e][FL_DIRTY] = 0;
				end
			end
			FN_TRANSFER: begin
				if (!sh_phys[src][PV_BIT]) st = ST_SRC_UNALLOC;
				else if (sh_phys[e][PV_BIT]) st = ST_DST_ALLOC;
				else begin
					sh_phys[e] = sh_phys[src];
					sh_phys[src] = '0;
					stamp_entry(e);
				end
			end
			FN_ACQUIRE: begin
				if (!sh_flags[e][FL_TEMP]) st = ST_NOT_TEMP;
				else begin
					if (!sh_phys[e][PV_BIT]) st = obtain_reg(e);
					if (st == ST_OK) begin
						sh_flags[e][FL_DIRTY] = 1;
						stamp_entry(e);
					end
				end
			end
			FN_RELEASE: begin
				if (!sh_flags[e][FL_TEMP]) st = ST_NOT_TEMP;
				else begin
					if (sh_phys[e][PV_BIT]) begin
						st = free_reg(sh_phys[e]);
						if (st == ST_OK) sh_phys[e] = '0;
					end
					// A released temporary looks eight stamps old.
					if (st == ST_OK) sh_age[e] = sh_clock - 32'd8;
				end
			end
			FN_GET_REAL: if (!sh_phys[e][PV_BIT]) st = ST_NOT_ALLOC;
			default: ;
			endcase
		end
		if (newh >= 0) begin
			h = 8'(newh);
			rep = newh;
		end
		if (st == ST_OK && rep >= 0 && sh_phys[rep][PV_BIT]) rp = sh_phys[rep][5:0];
		if (!load_done) push_result(st, h, rp, EMIT_NONE, BASE_STATE, 16'd0);
		foreach (step_res[i]) step_res[i].loaded = ld;
		step_res[step_res.size() - 1].last = 1'b1;
		foreach (step_res[i]) expected_results.push_back(step_res[i]);
	endfunction

	// Checks each result transfer against the oldest expectation.
	always @(posedge clk) begin
		alloc_result_t got, exp_r;
		if (arst_n && strobe) begin
			got = '{status, handle, phys_reg, emit_kind, mem_base, mem_offset, loaded, last};
			results_seen++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected result transfer: %p", got);
			end else begin
				exp_r = expected_results.pop_front();
				if (got !== exp_r) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch at %0t: expected %p, got %p", $realtime, exp_r, got);
				end
			end
		end
	end

	// Watchdog: counts cycles in which no transfer happens in either direction.
	always @(posedge clk) begin
		if (!arst_n || strobe || (start && !busy)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			timed_out <= 1'b1;
			$display("Watchdog expired after %0d idle cycles", quiet_cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Sends one command: optional random idle cycles, then holds start until accepted.
	// Start stays high after the accepting edge; the next idle cycle or drain drops it.
	task automatic send_command(logic [4:0] fn, logic [7:0] lid, logic [7:0] sid,
			logic [15:0] off, logic [5:0] pidx);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		func <= fn; logical_id <= lid; source_id <= sid;
		location_offset <= off; phys_index <= pidx;
		@(posedge clk);
		while (busy) @(posedge clk);
		// The command is taken at this edge; predict from the pre-command state.
		predict_command(fn, lid, sid, off, pidx);
		commands_sent++;
	endtask

	// Waits until every expected result has arrived, then lets the block settle.
	task automatic drain_results();
		start <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_pool_size(logic [6:0] value);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sh_pool_size = value;
		@(posedge clk);
	endtask

	// Directed commands: every operation, field extremes and the named corner cases.
	task automatic test_directed();
		send_command(FN_GET_REAL, 8'd0, 8'd0, 16'd0, 6'd0);       // handle not yet allocated
		send_command(FN_ALLOC_STATE, 8'd0, 8'd0, 16'hFFFF, 6'd0);
		send_command(FN_ALLOC_STACK, 8'd0, 8'd0, 16'h0000, 6'd0);
		send_command(FN_ALLOC_TEMP, 8'd0, 8'd0, 16'h1234, 6'd0);
		send_command(FN_ALLOC_NAMED, 8'd0, 8'd0, 16'd0, 6'd63);    // beyond the pool
		send_command(FN_ALLOC_NAMED, 8'd0, 8'd0, 16'd0, 6'd1);
		send_command(FN_ALLOC_NAMED, 8'd0, 8'd0, 16'd0, 6'd1);     // already held
		send_command(FN_LIVE, 8'd0, 8'd0, 16'd0, 6'd0);
		send_command(FN_DIRTY, 8'd0, 8'd0, 16'd0, 6'd0);
		send_command(FN_LIVE_STACK, 8'd1, 8'd0, 16'd0, 6'd0);      // no state home
		send_command(FN_LIVE_STACK, 8'd0, 8'd0, 16'd0, 6'd0);
		send_command(FN_LIVE_NOLOAD, 8'd1, 8'd0, 16'd0, 6'd0);
		send_command(FN_TRANSFER, 8'd2, 8'd1, 16'd0, 6'd0);
		send_command(FN_TRANSFER, 8'd2, 8'd1, 16'd0, 6'd0);        // source now empty
		send_command(FN_ACQUIRE, 8'd0, 8'd0, 16'd0, 6'd0);         // not a temporary
		send_command(FN_RELEASE, 8'd2, 8'd0, 16'd0, 6'd0);
		send_command(FN_PIN, 8'd0, 8'd0, 16'd0, 6'd0);
		send_command(FN_SPILL, 8'd0, 8'd0, 16'd0, 6'd0);           // pinned only restamps
		send_command(FN_UNPIN, 8'd0, 8'd0, 16'd0, 6'd0);
		send_command(FN_SPILL_STACK, 8'd0, 8'd0, 16'd0, 6'd0);
		send_command(FN_CLEAN, 8'd0, 8'd0, 16'd0, 6'd0);
		send_command(FN_TOUCH, 8'd255, 8'd255, 16'd0, 6'd0);
		send_command(FN_TRANSFER, 8'd0, 8'd200, 16'd0, 6'd0);      // bad source handle
		send_command(5'd31, 8'hFF, 8'hFF, 16'hFFFF, 6'h3F);        // unused code
		send_command(FN_RESET, 8'd0, 8'd0, 16'd0, 6'd0);
	endtask

	// A pool of one with several state entries forces eviction and dirty spills.
	task automatic test_eviction();
		write_pool_size(7'd1);
		for (int i = 0; i < 4; i++)
			send_command(FN_ALLOC_STATE, 8'd0, 8'd0, 16'($urandom), 6'd0);
		for (int i = 0; i < 12; i++) begin
			send_command(FN_LIVE, 8'(i % 4), 8'd0, 16'd0, 6'd0);
			send_command(FN_DIRTY, 8'(i % 4), 8'd0, 16'd0, 6'd0);
		end
		write_pool_size(7'd0);
		send_command(FN_LIVE_NOLOAD, 8'd0, 8'd0, 16'd0, 6'd0);
		send_command(FN_ALLOC_NAMED, 8'd0, 8'd0, 16'd0, 6'd0);
		write_pool_size(7'd127);
		send_command(FN_RESET, 8'd0, 8'd0, 16'd0, 6'd0);
	endtask

	// Random command picked mostly among handles that exist, weighted toward live traffic.
	task automatic send_random_command();
		logic [4:0] fn;
		logic [7:0] lid, sid;
		int pick;
		pick = $urandom_range(99);
		if (pick < 3) fn = 5'($urandom_range(19, 31));
		else if (pick < 4) fn = FN_RESET;
		else if (pick < 22) fn = 5'($urandom_range(FN_ALLOC_STATE, FN_ALLOC_NAMED));
		else if (pick < 50) fn = ($urandom_range(1)) ? FN_LIVE : FN_LIVE_STACK;
		else fn = 5'($urandom_range(FN_DIRTY, FN_GET_REAL));
		if (sh_count > 0 && $urandom_range(9) != 0) begin
			lid = 8'($urandom_range(sh_count - 1));
			sid = 8'($urandom_range(sh_count - 1));
		end else begin
			lid = 8'($urandom);
			sid = 8'($urandom);
		end
		send_command(fn, lid, sid, 16'($urandom), 6'($urandom_range(pool_limit() + 3)));
	endtask

	// Random traffic across several pool sizes, with a back-to-back stretch and a table-full burst.
	task automatic test_random_traffic();
		logic [6:0] sizes [5] = '{7'd3, 7'd8, 7'd64, 7'd16, 7'd100};
		foreach (sizes[s]) begin
			write_pool_size(sizes[s]);
			idle_pct = (s == 2) ? 0 : 22;
			for (int i = 0; i < 210; i++) send_random_command();
		end
		idle_pct = 22;
		// Fill the whole entry table so that further allocations report it full.
		send_command(FN_RESET, 8'd0, 8'd0, 16'd0, 6'd0);
		for (int i = 0; i < 258; i++)
			send_command(5'($urandom_range(FN_ALLOC_STATE, FN_ALLOC_TEMP)), 8'd0, 8'd0,
				16'($urandom), 6'd0);
		for (int i = 0; i < 40; i++) send_random_command();
	endtask

	initial begin
		clk = 0; arst_n = 0; start = 0; cfg_we = 0; cfg_wdata = '0;
		func = '0; logical_id = '0; source_id = '0; location_offset = '0; phys_index = '0;
		mismatches = 0; results_seen = 0; commands_sent = 0; idle_pct = 22;
		quiet_cycles = 0; timed_out = 0;
		foreach (sh_in_use[i]) sh_in_use[i] = 0;
		sh_count = 0; sh_clock = '0; sh_pool_size = PHYS_COUNT_RST;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_eviction();
		test_random_traffic();
		drain_results();
		$display("Sent %0d commands and checked %0d result transfers over pool sizes 0 to 127.",
			commands_sent, results_seen);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches, %0d expectations left", mismatches,
				expected_results.size());
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+src
src/lra_pkg.sv
src/lra_ctrl.sv
src/lra_dp.sv
src/lru_register_allocator_top.sv
tb/tb_lru_register_allocator_top.sv
